/* hdl/button_pulse_toggle_sequencer_macros.svh */
// assertion helpers shared by the sequencer modules
`ifndef BUTTON_PULSE_TOGGLE_SEQUENCER_MACROS_SVH
`define BUTTON_PULSE_TOGGLE_SEQUENCER_MACROS_SVH

// clocked property, disabled while reset is asserted
`define BPTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// same-cycle implication
`define BPTS_ASSERT_IMP(lbl, ante, cons, msg) \
  `BPTS_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define BPTS_ASSERT_NXT(lbl, ante, cons, msg) \
  `BPTS_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

/* hdl/bpts_pkg.sv */
package bpts_pkg;

  // field widths
  localparam int unsigned HOLD_W   = 10;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned GAIN_W   = 4;
  localparam int unsigned TOG_W    = 3;
  localparam int unsigned CFG_IDX_W = 1;

  // parameter defaults
  localparam int unsigned NUM_BUTTONS_DEF = 5;
  localparam int unsigned HOLD_CAP_DEF    = 1000;

  // reset and limits
  localparam logic [HOLD_W-1:0] HOLD_RESET = 10'd75;
  localparam logic [GAIN_W-1:0] GAIN_MIN   = 4'd5;
  localparam logic [GAIN_W-1:0] GAIN_MAX   = 4'd15;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 4'd10;

  // toggle loads per action
  localparam logic [TOG_W-1:0] TOG_PREV = 3'd6;
  localparam logic [TOG_W-1:0] TOG_PLAY = 3'd2;
  localparam logic [TOG_W-1:0] TOG_NEXT = 3'd4;
  localparam logic [TOG_W-1:0] TOG_MAX  = 3'd6;

  // button slot assignment
  localparam int unsigned SLOT_VOL_DOWN = 0;
  localparam int unsigned SLOT_PREV     = 1;
  localparam int unsigned SLOT_PLAY     = 2;
  localparam int unsigned SLOT_NEXT     = 3;
  localparam int unsigned SLOT_VOL_UP   = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE     = 3'd0,
    CMD_VOL_DOWN = 3'd1,
    CMD_PREV     = 3'd2,
    CMD_PLAY     = 3'd3,
    CMD_PAUSE    = 3'd4,
    CMD_NEXT     = 3'd5,
    CMD_VOL_UP   = 3'd6
  } remote_cmd_e;

  typedef enum logic [1:0] {
    RES_NONE    = 2'd0,
    RES_DEFAULT = 2'd1,
    RES_MIN     = 2'd2
  } res_write_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEFAULT_HOLD = 1'b0,
    CFG_MIN_HOLD     = 1'b1
  } cfg_reg_e;

  // decoded local press for one tick
  typedef struct packed {
    logic vol_down;
    logic prev;
    logic play;
    logic next;
    logic vol_up;
  } press_t;

  // one result item
  typedef struct packed {
    logic [1:0]        resistance_write;
    logic              play_report;
    logic              playing_now;
    logic [GAIN_W-1:0] gain_tenths;
    logic [TOG_W-1:0]  toggles_left;
  } result_t;

endpackage

/* hdl/bpts_if.sv */
// input channel: one tick
interface bpts_in_if;
  logic       valid;
  logic       ready;
  logic       button_level;
  logic [2:0] remote_cmd;

  modport source (output valid, output button_level, output remote_cmd, input ready);
  modport sink   (input valid, input button_level, input remote_cmd, output ready);
endinterface

// output channel: one result per tick
interface bpts_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] resistance_write;
  logic       play_report;
  logic       playing_now;
  logic [3:0] gain_tenths;
  logic [2:0] toggles_left;

  modport source (output valid, output resistance_write, output play_report,
                  output playing_now, output gain_tenths, output toggles_left,
                  input ready);
  modport sink   (input valid, input resistance_write, input play_report,
                  input playing_now, input gain_tenths, input toggles_left,
                  output ready);
endinterface

/* hdl/bpts_slot_tracker.sv */
module bpts_slot_tracker
  import bpts_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   adv_i,
  input  logic   level_i,
  output press_t press_o
);

  localparam int unsigned SLOT_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_BUTTONS - 1);

  logic [SLOT_W-1:0]      slot_q, slot_d;
  logic [NUM_BUTTONS-1:0] prev_q, prev_d;
  logic                   rise;

  // rising edge against the last sample of this slot
  assign rise = level_i & ~prev_q[slot_q];

  always_comb begin
    prev_d         = prev_q;
    prev_d[slot_q] = level_i;
    slot_d         = (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
  end

  // slot decode, slots past the button count never match
  always_comb begin
    press_o.vol_down = rise && (NUM_BUTTONS > SLOT_VOL_DOWN)
                       && (slot_q == SLOT_W'(SLOT_VOL_DOWN));
    press_o.prev     = rise && (NUM_BUTTONS > SLOT_PREV)
                       && (slot_q == SLOT_W'(SLOT_PREV));
    press_o.play     = rise && (NUM_BUTTONS > SLOT_PLAY)
                       && (slot_q == SLOT_W'(SLOT_PLAY));
    press_o.next     = rise && (NUM_BUTTONS > SLOT_NEXT)
                       && (slot_q == SLOT_W'(SLOT_NEXT));
    press_o.vol_up   = rise && (NUM_BUTTONS > SLOT_VOL_UP)
                       && (slot_q == SLOT_W'(SLOT_VOL_UP));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      prev_q <= '0;
    end else if (adv_i) begin
      slot_q <= slot_d;
      prev_q <= prev_d;
    end
  end

endmodule

/* hdl/bpts_ctrl.sv */
`include "button_pulse_toggle_sequencer_macros.svh"

module bpts_ctrl
  import bpts_pkg::*;
#(
  parameter int unsigned HOLD_CAP = HOLD_CAP_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  press_t               press_i,
  input  logic [CMD_W-1:0]     cmd_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [HOLD_W-1:0]    cfg_data_i,
  output result_t              res_o
);

  localparam logic [HOLD_W-1:0] CAP = HOLD_W'(HOLD_CAP);

  logic [HOLD_W-1:0] dflt_hold_q, min_hold_q;
  logic [HOLD_W-1:0] hold_q, hold_d, hold_inc, thr;
  logic [TOG_W-1:0]  pend_q, pend_d, pend_fire, pend_local;
  logic              play_q, play_d, play_local;
  logic [GAIN_W-1:0] gain_q, gain_d, gain_local;
  logic              fire;
  res_write_e        wr;

  function automatic logic [GAIN_W-1:0] gain_step(logic [GAIN_W-1:0] g, logic up,
                                                   logic dn);
    logic [GAIN_W-1:0] r;
    r = g;
    if (up && (g < GAIN_MAX)) r = g + 1'b1;
    if (dn && (g > GAIN_MIN)) r = g - 1'b1;
    return r;
  endfunction

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_hold_q <= HOLD_RESET;
      min_hold_q  <= HOLD_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_DEFAULT_HOLD: dflt_hold_q <= cfg_data_i;
        CFG_MIN_HOLD:     min_hold_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // saturating hold count and toggle timing
  always_comb begin
    hold_inc  = (hold_q >= CAP) ? CAP : hold_q + 1'b1;
    thr       = pend_q[0] ? dflt_hold_q : min_hold_q;
    fire      = (pend_q != '0) && (hold_inc >= thr);
    wr        = !fire ? RES_NONE : (pend_q[0] ? RES_DEFAULT : RES_MIN);
    hold_d    = fire ? '0 : hold_inc;
    pend_fire = fire ? pend_q - 1'b1 : pend_q;
  end

  // local press, toggle loads only while nothing is pending
  always_comb begin
    pend_local = pend_fire;
    play_local = play_q;
    if (pend_fire == '0) begin
      if (press_i.prev) pend_local = TOG_PREV;
      if (press_i.play) pend_local = TOG_PLAY;
      if (press_i.next) pend_local = TOG_NEXT;
    end
    if (press_i.play) play_local = ~play_q;
    gain_local = gain_step(gain_q, press_i.vol_up, press_i.vol_down);
  end

  // remote command, applied after the local press
  always_comb begin
    pend_d = pend_local;
    play_d = play_local;
    gain_d = gain_local;
    case (remote_cmd_e'(cmd_i))
      CMD_VOL_DOWN: gain_d = gain_step(gain_local, 1'b0, 1'b1);
      CMD_PREV:     pend_d = TOG_PREV;
      CMD_PLAY: begin
        pend_d = TOG_PLAY;
        play_d = 1'b1;
      end
      CMD_PAUSE: begin
        pend_d = TOG_PLAY;
        play_d = 1'b0;
      end
      CMD_NEXT:     pend_d = TOG_NEXT;
      CMD_VOL_UP:   gain_d = gain_step(gain_local, 1'b1, 1'b0);
      default: ;
    endcase
  end

  always_comb begin
    res_o.resistance_write = wr;
    res_o.play_report      = press_i.play;
    res_o.playing_now      = play_d;
    res_o.gain_tenths      = gain_d;
    res_o.toggles_left     = pend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= '0;
      pend_q <= '0;
      play_q <= 1'b1;
      gain_q <= GAIN_RESET;
    end else if (adv_i) begin
      hold_q <= hold_d;
      pend_q <= pend_d;
      play_q <= play_d;
      gain_q <= gain_d;
    end
  end

  `BPTS_ASSERT_IMP(a_pend_range, 1'b1, pend_q <= TOG_MAX, "pending toggles above six")
  `BPTS_ASSERT_IMP(a_gain_range, 1'b1, (gain_q >= GAIN_MIN) && (gain_q <= GAIN_MAX),
                   "gain out of range")
  `BPTS_ASSERT_IMP(a_hold_cap, 1'b1, hold_q <= CAP, "hold count above cap")
  `BPTS_ASSERT_NXT(a_fire_clears, adv_i && fire, hold_q == '0,
                   "hold count not cleared after a write")

endmodule

/* hdl/button_pulse_toggle_sequencer.sv */
// channel   dir  payload                                         transaction
// in_i      in   button_level, remote_cmd                        valid & ready
// out_o     out  resistance_write, play_report, playing_now,     valid & ready
//                gain_tenths, toggles_left
// cfg       in   cfg_idx_i, cfg_data_i                           cfg_we_i
//
// one tick per cycle sustained while the output is not stalled; a tick is held in the input register
// and its result is then registered in the output register
// the tick update is one combinational pass from input register to state and result
// reset: slot 0, levels low, no toggles pending, hold 0, playing, gain 10, holds 75
// a stalled output holds its result; the input register still takes one more tick

`include "button_pulse_toggle_sequencer_macros.svh"

module button_pulse_toggle_sequencer
  import bpts_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = NUM_BUTTONS_DEF,
  parameter int unsigned HOLD_CAP    = HOLD_CAP_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bpts_in_if.sink              in_i,
  bpts_out_if.source           out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [HOLD_W-1:0]    cfg_data_i
);

  logic             s1_valid_q, s1_valid_d;
  logic             s1_level_q;
  logic [CMD_W-1:0] s1_cmd_q;
  logic             out_valid_q, out_valid_d;
  result_t          out_q, res;
  press_t           press;
  logic             adv, in_take;

  // stage advance: input register moves into the output register
  assign adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || adv;
  assign in_take = in_i.valid && in_i.ready;

  assign s1_valid_d  = in_take ? 1'b1 : (adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = adv ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_level_q <= in_i.button_level;
      s1_cmd_q   <= in_i.remote_cmd;
    end
  end

  bpts_slot_tracker #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) u_slot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .level_i(s1_level_q),
    .press_o(press)
  );

  bpts_ctrl #(
    .HOLD_CAP(HOLD_CAP)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .press_i   (press),
    .cmd_i     (s1_cmd_q),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .res_o     (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.resistance_write = out_q.resistance_write;
  assign out_o.play_report      = out_q.play_report;
  assign out_o.playing_now      = out_q.playing_now;
  assign out_o.gain_tenths      = out_q.gain_tenths;
  assign out_o.toggles_left     = out_q.toggles_left;

  `BPTS_ASSERT_NXT(a_adv_shows, adv, out_valid_q, "advanced tick not presented")
  `BPTS_ASSERT_IMP(a_no_overrun, adv && out_valid_q, out_o.ready,
                   "result overwritten while stalled")
  `BPTS_ASSERT_IMP(a_wr_code, out_valid_q, out_q.resistance_write != 2'd3,
                   "illegal resistance write code")

endmodule
